// ===== hw/rtl/rcmr_pkg.sv =====
// Package with widths, constants and beat types for the rod cutting revenue unit.
package rcmr_pkg;

    localparam int PRICE_W             = 16;
    localparam int REV_W               = 22;
    localparam int DEFAULT_MAX_ROD_LEN = 64;

    localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

    typedef struct packed {
        logic [PRICE_W-1:0] piece_price;
        logic               is_last;
    } in_beat_t;

    typedef struct packed {
        logic [REV_W-1:0] best_revenue;
        logic             too_long;
    } out_beat_t;

endpackage

// ===== hw/rtl/rod_cutting_max_revenue_unit.sv =====
// Top level of the rod cutting revenue unit: table memory, shared adder and sequencer.
//
// Usage: prices arrive on the s_ channel one beat at a time; beat k carries the price
// of a piece of length k+1, and is_last closes the list. After the last beat one
// result beat leaves on the m_ channel with the best revenue for a rod whose length
// is the number of prices, and too_long set when more than MAX_ROD_LEN prices came.
// Each taken price sweeps the revenue table through one shared saturating adder and
// compare, one table entry per cycle, pipelined across the registered memory read.
// The first price of a list sweeps entries 0 to MAX_ROD_LEN; a later price k+1, with k
// of one or more, sweeps entries k+1 to MAX_ROD_LEN; a price beyond the bound only
// flags too_long. A last beat adds a read of the result entry. s_ready is high only
// while the sequencer is idle.
// The result sits in an output register, so the next list can start while it waits;
// a stalled receiver only blocks the unit when the following result is ready too.
// Reset clears the sequencer, the counters and the output valid; the table memory is
// not cleared, since the first price of every list rewrites all of it.
module rod_cutting_max_revenue_unit
    import rcmr_pkg::*;
#(
    parameter int MAX_ROD_LEN = DEFAULT_MAX_ROD_LEN
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int ADDR_W = $clog2(MAX_ROD_LEN + 1);
    localparam logic [ADDR_W-1:0] LAST_N = ADDR_W'(MAX_ROD_LEN);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SWEEP  = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_RESULT = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [REV_W-1:0]   best_mem [0:MAX_ROD_LEN];
    logic [REV_W-1:0]   rdata_a_reg, rdata_b_reg;

    logic [ADDR_W-1:0]  prices_seen_reg;
    logic               overflow_seen_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [ADDR_W-1:0]  len_reg;
    logic               first_reg;
    logic               last_reg;

    logic [ADDR_W-1:0]  issue_n_reg;
    logic               s2_valid_reg;
    logic [ADDR_W-1:0]  s2_n_reg, s2_lo_reg;

    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  wr_addr_last_reg;
    logic [REV_W-1:0]   wr_data_last_reg;

    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    logic               s_fire, take_price, issuing, out_free;
    logic               rd_a_en;
    logic [ADDR_W-1:0]  rd_a_addr, rd_b_addr;
    logic [REV_W-1:0]   lo_val, add_b, cand, wr_data;
    logic [REV_W:0]     sum;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign take_price = (prices_seen_reg < LAST_N);
    assign issuing    = (state_reg == ST_SWEEP);
    assign out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Port A reads the entry being updated, or the result entry at the end of a list.
    assign rd_a_en   = issuing || (state_reg == ST_FETCH);
    assign rd_a_addr = issuing ? issue_n_reg : prices_seen_reg;
    assign rd_b_addr = issue_n_reg - len_reg;

    // The entry written on the previous edge has not reached the read data yet.
    assign lo_val = (fwd_valid_reg && (s2_lo_reg == wr_addr_last_reg)) ? wr_data_last_reg
                                                                       : rdata_b_reg;
    // The first price builds n * price as a saturating running sum.
    assign add_b = first_reg ? wr_data_last_reg : lo_val;
    assign sum   = {1'b0, {(REV_W - PRICE_W){1'b0}}, price_reg} + {1'b0, add_b};
    assign cand  = sum[REV_W] ? REV_MAX : sum[REV_W-1:0];

    always_comb begin
        if (first_reg) begin
            wr_data = (s2_n_reg == '0) ? '0 : cand;
        end else begin
            wr_data = (cand > rdata_a_reg) ? cand : rdata_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            best_mem[s2_n_reg] <= wr_data;
        end
        if (rd_a_en) begin
            rdata_a_reg <= best_mem[rd_a_addr];
        end
        // The first price needs no lower entry, and its address would fall off the table.
        if (issuing && !first_reg) begin
            rdata_b_reg <= best_mem[rd_b_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (take_price) begin
                        state_next = ST_SWEEP;
                    end else if (s_data.is_last) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SWEEP: begin
                if (issue_n_reg == LAST_N) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = last_reg ? ST_FETCH : ST_IDLE;
            end
            ST_FETCH: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            prices_seen_reg   <= '0;
            overflow_seen_reg <= 1'b0;
            s2_valid_reg      <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            s2_valid_reg  <= issuing;
            fwd_valid_reg <= s2_valid_reg;

            if (s_fire) begin
                if (take_price) begin
                    prices_seen_reg <= prices_seen_reg + 1'b1;
                end else begin
                    overflow_seen_reg <= 1'b1;
                end
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_RESULT) && out_free) begin
                m_valid_reg       <= 1'b1;
                prices_seen_reg   <= '0;
                overflow_seen_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            last_reg <= s_data.is_last;
            if (take_price) begin
                price_reg   <= s_data.piece_price;
                len_reg     <= prices_seen_reg + 1'b1;
                first_reg   <= (prices_seen_reg == '0);
                issue_n_reg <= (prices_seen_reg == '0) ? '0 : prices_seen_reg + 1'b1;
            end
        end else if (issuing) begin
            issue_n_reg <= issue_n_reg + 1'b1;
        end

        if (issuing) begin
            s2_n_reg  <= issue_n_reg;
            s2_lo_reg <= rd_b_addr;
        end

        if (s2_valid_reg) begin
            wr_addr_last_reg <= s2_n_reg;
            wr_data_last_reg <= wr_data;
        end

        if ((state_reg == ST_RESULT) && out_free) begin
            m_data_reg.best_revenue <= rdata_a_reg;
            m_data_reg.too_long     <= overflow_seen_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !s2_valid_reg)
        else $error("table written while the sequencer is idle");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issuing |-> (issue_n_reg <= LAST_N))
        else $error("sweep address beyond the table bound");

    a_lo_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !first_reg) |-> (s2_lo_reg < s2_n_reg))
        else $error("update reads an entry at or above the one it writes");

    a_result_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |-> (prices_seen_reg != '0))
        else $error("result requested for an empty price list");

    a_drain_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> !s2_valid_reg)
        else $error("sweep pipeline still busy after drain");
`endif

endmodule
